[rtl/inverse_park_clarke_pwm_defines.svh]
// assertion macros for the inverse park / clarke pwm block
// used by the port checker; expects clk and rst_n in the including scope
`ifndef INVERSE_PARK_CLARKE_PWM_DEFINES_SVH
`define INVERSE_PARK_CLARKE_PWM_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IPCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define IPCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ipcp_pkg.sv]
// shared widths, constants, tables and beat types of the inverse park / clarke pwm block
// no dependencies
`default_nettype none

package ipcp_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int ANGLE_W        = 12;
  localparam int ANGLE_MAX_W    = 16;
  localparam int UQ_W           = 16;
  localparam int CMP_W          = 16;
  localparam int REG_W          = 16;
  localparam int NUM_PHASES     = 3;

  localparam int IN_TDATA_W  = 8 * ((UQ_W + ANGLE_W + 7) / 8);
  localparam int OUT_TDATA_W = 8 * ((NUM_PHASES * CMP_W + 7) / 8);

  // cordic datapath
  localparam int CORDIC_STEPS = 16;
  localparam int CRD_W        = 32;
  localparam int SC_W         = 16;
  localparam int SC_SHIFT     = 16;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam crd_t CORDIC_X0 = 32'sd652032874;

  // arctangent per step, 2^32 per turn
  localparam crd_t ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  // post processing
  localparam int AB_W       = 31;
  localparam int SQ_W       = 19;
  localparam int SQ_SHIFT   = 16;
  localparam int PH_W       = 33;
  localparam int HALF_SHIFT = 13;
  localparam int DIV_SHIFT  = 14;
  localparam int U_W        = REG_W + DIV_SHIFT;
  localparam int PRD_W      = U_W + REG_W;
  localparam int NUM_W      = PRD_W - DIV_SHIFT;

  localparam logic signed [SQ_W-1:0] SQRT3_Q16 = 19'sd113512;

  localparam int POST_STAGES = 6;
  localparam int DIV_STEPS   = CMP_W;
  localparam int PIPE_STAGES = CORDIC_STEPS + POST_STAGES + DIV_STEPS;

  // configuration registers
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_SUPPLY = 2'd0;
  localparam reg_idx_t REG_LIMIT  = 2'd1;
  localparam reg_idx_t REG_PERIOD = 2'd2;

  localparam logic [REG_W-1:0] SUPPLY_RST = 16'd3072;
  localparam logic [REG_W-1:0] LIMIT_RST  = 16'd3072;
  localparam logic [REG_W-1:0] PERIOD_RST = 16'd4800;

  // beat moving down the cordic row
  typedef struct packed {
    logic                   valid;
    logic                   motor;
    logic signed [UQ_W-1:0] uq;
    logic                   flip;
    crd_t                   x;
    crd_t                   y;
    crd_t                   z;
  } crd_beat_t;

  // one phase inside the divider row
  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [CMP_W-1:0] num;
    logic [CMP_W-1:0] quo;
  } div_lane_t;

  // beat moving down the divider row
  typedef struct packed {
    logic                             valid;
    logic                             motor;
    logic                             zero_sup;
    logic [NUM_PHASES-1:0]            sat;
    div_lane_t [NUM_PHASES-1:0]       lane;
  } div_beat_t;

endpackage

`default_nettype wire

[rtl/ipcp_cordic_cell.sv]
// one rotation step of the sine / cosine cordic row
// depends on ipcp_pkg for the beat type and the arctangent table
`default_nettype none

module ipcp_cordic_cell
  import ipcp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  crd_beat_t d_in,
  output crd_beat_t d_out
);

  crd_beat_t beat_r;
  crd_beat_t beat_nxt;
  crd_t      dx;
  crd_t      dy;

  always_comb begin
    dx       = d_in.y >>> STEP;
    dy       = d_in.x >>> STEP;
    beat_nxt = d_in;
    if (!d_in.z[CRD_W-1]) begin
      beat_nxt.x = d_in.x - dx;
      beat_nxt.y = d_in.y + dy;
      beat_nxt.z = d_in.z - ATAN_TAB[STEP];
    end else begin
      beat_nxt.x = d_in.x + dx;
      beat_nxt.y = d_in.y - dy;
      beat_nxt.z = d_in.z + ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

`default_nettype wire

[rtl/ipcp_div_cell.sv]
// one restoring-division step for all three phases, one quotient bit per cell
// depends on ipcp_pkg for the divider beat type
`default_nettype none

module ipcp_div_cell
  import ipcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [REG_W-1:0] divisor,
  input  div_beat_t        d_in,
  output div_beat_t        d_out
);

  logic [CMP_W:0] trial [NUM_PHASES];
  logic [CMP_W:0] diff  [NUM_PHASES];
  logic           take  [NUM_PHASES];
  div_beat_t      beat_r;
  div_beat_t      beat_nxt;

  always_comb begin
    beat_nxt = d_in;
    for (int k = 0; k < NUM_PHASES; k++) begin
      trial[k] = {d_in.lane[k].rem, d_in.lane[k].num[CMP_W-1]};
      diff[k]  = trial[k] - {1'b0, divisor};
      take[k]  = (trial[k] >= {1'b0, divisor});
      beat_nxt.lane[k].rem = take[k] ? diff[k][CMP_W-1:0] : trial[k][CMP_W-1:0];
      beat_nxt.lane[k].num = {d_in.lane[k].num[CMP_W-2:0], 1'b0};
      beat_nxt.lane[k].quo = {d_in.lane[k].quo[CMP_W-2:0], take[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

`default_nettype wire

[rtl/inverse_park_clarke_pwm.sv]
// top level: inverse park / clarke transform with sinusoidal pwm compare values
// depends on ipcp_pkg, ipcp_cordic_cell and ipcp_div_cell
//
// usage
// - input channel in_*: one beat per control update; in_tdata carries uq_cmd in
//   bits 15:0 (signed q8.8 volts) and elec_angle in bits 27:16, in_tuser the motor
// - output channel out_*: one beat per input beat, in order; out_tdata carries
//   cmp_a, cmp_b, cmp_c (16 bits each, lowest first), out_tuser the motor number
// - configuration channel cfg_*: index 0 supply, 1 phase limit, 2 pwm period;
//   cfg_ready is always high, other indexes are dropped; write only while idle
// - throughput: one beat per cycle, sustained while out_tready stays high, set by the fully pipelined rows
// - pipeline: 16 cordic cells, 6 post stages (round, two multiplies, phase sum,
//   clamp, period multiply) and 16 divider cells, one quotient bit each
// - stall: the output register holds a beat while out_tready is low, one more
//   beat lands in a skid register, then in_tready drops until the skid drains
// - reset (rst_n low, synchronous): all pipeline valids clear, the registers
//   return to supply 3072, limit 3072, period 4800; no clearing pass is needed
`default_nettype none

module inverse_park_clarke_pwm
  import ipcp_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // uq_cmd [15:0], elec_angle [27:16], zero pad
  input  logic                   in_tuser,    // motor_sel

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // cmp_a [15:0], cmp_b [31:16], cmp_c [47:32]
  output logic                   out_tuser,   // motor_out

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  reg_idx_t               cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  // post-stage beat types
  typedef struct packed {
    logic                   valid;
    logic                   motor;
    logic signed [UQ_W-1:0] uq;
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } p1_t;

  typedef struct packed {
    logic                   valid;
    logic                   motor;
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
  } p2_t;

  typedef struct packed {
    logic                   valid;
    logic                   motor;
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] sb;
  } p3_t;

  typedef struct packed {
    logic                   valid;
    logic                   motor;
    logic signed [PH_W-1:0] ua;
    logic signed [PH_W-1:0] ub;
    logic signed [PH_W-1:0] uc;
  } p4_t;

  typedef struct packed {
    logic                             valid;
    logic                             motor;
    logic                             zero_sup;
    logic [NUM_PHASES-1:0]            sat;
    logic [NUM_PHASES-1:0][U_W-1:0]   u;
  } p5_t;

  localparam logic signed [CRD_W:0] RND_HALF = (CRD_W+1)'(32768);
  localparam logic signed [CRD_W:0] Q14_MAX  = (CRD_W+1)'(16384);
  localparam logic signed [CRD_W:0] Q14_MIN  = -Q14_MAX;

  // configuration registers
  logic [REG_W-1:0] supply_r;
  logic [REG_W-1:0] limit_r;
  logic [REG_W-1:0] period_r;

  // pipeline enable, low while the skid register is full
  logic en;

  // angle fold into the right half plane
  logic [ANGLE_MAX_W-1:0] angle_ext;
  logic [CRD_W-1:0]       phase_w;
  logic                   flip_w;
  crd_beat_t              crd_head;
  crd_beat_t              crd_chain [CORDIC_STEPS+1];

  // post stages
  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  p3_t p3_r, p3_nxt;
  p4_t p4_r, p4_nxt;
  p5_t p5_r, p5_nxt;
  div_beat_t div_head_r, div_head_nxt;
  div_beat_t div_chain [DIV_STEPS+1];

  logic signed [2*UQ_W-1:0]  prod_s;
  logic signed [2*UQ_W-1:0]  prod_c;
  logic signed [AB_W+SQ_W-1:0] prod_sb;
  logic signed [PH_W-1:0]    a_w;
  logic signed [PH_W-1:0]    sb_w;
  logic signed [PH_W-1:0]    half_w;
  logic signed [PH_W-1:0]    diff_b;
  logic signed [PH_W-1:0]    sum_c;
  logic signed [PH_W-1:0]    ph_v   [NUM_PHASES];
  logic [U_W-1:0]            lim_w;
  logic [U_W-1:0]            divv_w;
  logic [U_W-1:0]            clip   [NUM_PHASES];
  logic [PRD_W-1:0]          prd    [NUM_PHASES];
  logic [NUM_W-1:0]          numr   [NUM_PHASES];

  // result and output skid
  div_beat_t              div_tail;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;
  logic                   skid_valid_r;
  logic [OUT_TDATA_W-1:0] skid_data_r;
  logic                   skid_user_r;

  // q.30 cordic output to rounded and clamped q2.14, with optional negation
  function automatic logic signed [SC_W-1:0] to_q14(input crd_t v, input logic neg);
    logic signed [CRD_W:0] w;
    logic signed [CRD_W:0] r;
    w = (CRD_W+1)'(v);
    if (neg) begin
      w = -w;
    end
    r = (w + RND_HALF) >>> SC_SHIFT;
    if (r > Q14_MAX) begin
      r = Q14_MAX;
    end else if (r < Q14_MIN) begin
      r = Q14_MIN;
    end
    return r[SC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RST;
      limit_r  <= LIMIT_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SUPPLY: supply_r <= cfg_data;
        REG_LIMIT:  limit_r  <= cfg_data;
        REG_PERIOD: period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input beat: widen the angle to a full-turn phase and fold the far half turn
  // ---------------------------------------------------------------------------
  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_comb begin
    angle_ext = {{(ANGLE_MAX_W-ANGLE_W){1'b0}}, in_tdata[UQ_W +: ANGLE_W]};
    phase_w   = {angle_ext[ANGLE_BITS-1:0], {(CRD_W-ANGLE_BITS){1'b0}}};
    // second and third quadrant: rotate by half a turn, negate at the end
    flip_w    = phase_w[CRD_W-1] ^ phase_w[CRD_W-2];

    crd_head.valid = in_tvalid;
    crd_head.motor = in_tuser;
    crd_head.uq    = $signed(in_tdata[UQ_W-1:0]);
    crd_head.flip  = flip_w;
    crd_head.x     = CORDIC_X0;
    crd_head.y     = '0;
    crd_head.z     = $signed({phase_w[CRD_W-1] ^ flip_w, phase_w[CRD_W-2:0]});
  end

  assign crd_chain[0] = crd_head;

  // ---------------------------------------------------------------------------
  // cordic row, one rotation per cell
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    ipcp_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (crd_chain[g]),
      .d_out (crd_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // post stages
  // ---------------------------------------------------------------------------
  always_comb begin
    // round: undo the fold and round to q2.14
    p1_nxt.valid = crd_chain[CORDIC_STEPS].valid;
    p1_nxt.motor = crd_chain[CORDIC_STEPS].motor;
    p1_nxt.uq    = crd_chain[CORDIC_STEPS].uq;
    p1_nxt.s     = to_q14(crd_chain[CORDIC_STEPS].y, crd_chain[CORDIC_STEPS].flip);
    p1_nxt.c     = to_q14(crd_chain[CORDIC_STEPS].x, crd_chain[CORDIC_STEPS].flip);

    // inverse park with zero d-axis command
    prod_s       = p1_r.uq * p1_r.s;
    prod_c       = p1_r.uq * p1_r.c;
    p2_nxt.valid = p1_r.valid;
    p2_nxt.motor = p1_r.motor;
    p2_nxt.alpha = AB_W'(-prod_s);
    p2_nxt.beta  = AB_W'(prod_c);

    // sqrt(3) * beta, floor shift
    prod_sb      = p2_r.beta * SQRT3_Q16;
    p3_nxt.valid = p2_r.valid;
    p3_nxt.motor = p2_r.motor;
    p3_nxt.alpha = p2_r.alpha;
    p3_nxt.sb    = AB_W'(prod_sb >>> SQ_SHIFT);

    // inverse clarke plus midpoint offset of half the supply
    a_w          = PH_W'(p3_r.alpha);
    sb_w         = PH_W'(p3_r.sb);
    half_w       = $signed(PH_W'({supply_r, {HALF_SHIFT{1'b0}}}));
    diff_b       = sb_w - a_w;
    sum_c        = -(a_w + sb_w);
    p4_nxt.valid = p3_r.valid;
    p4_nxt.motor = p3_r.motor;
    p4_nxt.ua    = a_w + half_w;
    p4_nxt.ub    = (diff_b >>> 1) + half_w;
    p4_nxt.uc    = (sum_c >>> 1) + half_w;

    // clamp to [0, limit], flag saturation against the supply
    ph_v[0]         = p4_r.ua;
    ph_v[1]         = p4_r.ub;
    ph_v[2]         = p4_r.uc;
    lim_w           = {limit_r, {DIV_SHIFT{1'b0}}};
    divv_w          = {supply_r, {DIV_SHIFT{1'b0}}};
    p5_nxt.valid    = p4_r.valid;
    p5_nxt.motor    = p4_r.motor;
    p5_nxt.zero_sup = (supply_r == '0);
    for (int k = 0; k < NUM_PHASES; k++) begin
      if (ph_v[k][PH_W-1]) begin
        clip[k] = '0;
      end else if (ph_v[k] > $signed({{(PH_W-U_W){1'b0}}, lim_w})) begin
        clip[k] = lim_w;
      end else begin
        clip[k] = ph_v[k][U_W-1:0];
      end
      p5_nxt.u[k]   = clip[k];
      // duty at or above one: compare value is the full period
      p5_nxt.sat[k] = (clip[k] >= divv_w);
    end

    // numerator u * period / 2^14, split into first remainder and low bits
    div_head_nxt.valid    = p5_r.valid;
    div_head_nxt.motor    = p5_r.motor;
    div_head_nxt.zero_sup = p5_r.zero_sup;
    div_head_nxt.sat      = p5_r.sat;
    for (int k = 0; k < NUM_PHASES; k++) begin
      prd[k] = PRD_W'(p5_r.u[k]) * PRD_W'(period_r);
      numr[k] = prd[k][PRD_W-1 -: NUM_W];
      div_head_nxt.lane[k].rem = numr[k][NUM_W-1 -: CMP_W];
      div_head_nxt.lane[k].num = numr[k][CMP_W-1:0];
      div_head_nxt.lane[k].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid       <= 1'b0;
      p2_r.valid       <= 1'b0;
      p3_r.valid       <= 1'b0;
      p4_r.valid       <= 1'b0;
      p5_r.valid       <= 1'b0;
      div_head_r.valid <= 1'b0;
    end else if (en) begin
      p1_r       <= p1_nxt;
      p2_r       <= p2_nxt;
      p3_r       <= p3_nxt;
      p4_r       <= p4_nxt;
      p5_r       <= p5_nxt;
      div_head_r <= div_head_nxt;
    end
  end

  assign div_chain[0] = div_head_r;

  // ---------------------------------------------------------------------------
  // divider row by the supply, one quotient bit per cell
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ipcp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .divisor (supply_r),
      .d_in    (div_chain[g]),
      .d_out   (div_chain[g+1])
    );
  end

  assign div_tail = div_chain[DIV_STEPS];

  // zero supply wins over saturation
  always_comb begin
    res_data = '0;
    for (int k = 0; k < NUM_PHASES; k++) begin
      if (div_tail.zero_sup) begin
        res_data[k*CMP_W +: CMP_W] = '0;
      end else if (div_tail.sat[k]) begin
        res_data[k*CMP_W +: CMP_W] = period_r;
      end else begin
        res_data[k*CMP_W +: CMP_W] = div_tail.lane[k].quo;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!skid_valid_r) begin
      if (out_valid_r && !out_tready) begin
        // output stalled: park the arriving beat
        if (div_tail.valid) begin
          skid_valid_r <= 1'b1;
          skid_data_r  <= res_data;
          skid_user_r  <= div_tail.motor;
        end
      end else begin
        out_valid_r <= div_tail.valid;
        out_data_r  <= res_data;
        out_user_r  <= div_tail.motor;
      end
    end else if (out_tready) begin
      out_data_r   <= skid_data_r;
      out_user_r   <= skid_user_r;
      skid_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

[rtl/ipcp_checker.sv]
// port-level checker for the inverse park / clarke pwm block, bound to the top level
// depends on ipcp_pkg and inverse_park_clarke_pwm_defines.svh
`default_nettype none
`include "inverse_park_clarke_pwm_defines.svh"

module ipcp_checker
  import ipcp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // pipeline stages plus output register plus skid entry
  localparam int CAP   = PIPE_STAGES + 2;
  localparam int CNT_W = $clog2(CAP + 1);

  logic [CNT_W-1:0] pending_r;
  logic [CNT_W-1:0] pending_nxt;

  assign pending_nxt = pending_r + CNT_W'(in_tvalid && in_tready)
                                 - CNT_W'(out_tvalid && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `IPCP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output beat changed")
  `IPCP_ASSERT_NOW(a_stall_cause, !in_tready, $past(out_tvalid && !out_tready), "input blocked without an output stall")
  `IPCP_ASSERT_NOW(a_no_phantom, out_tvalid, pending_r != '0, "output beat with no input beat in flight")
  `IPCP_ASSERT_NOW(a_depth, 1'b1, pending_r <= CNT_W'(CAP), "more beats in flight than the block can hold")

endmodule

bind inverse_park_clarke_pwm ipcp_checker u_ipcp_checker (.*);

`default_nettype wire
